// ===== src/qslerp_pkg.sv =====
`timescale 1ns / 1ps

package qslerp_pkg;

	// cordic length and fixed-point layout
	localparam int SINE_STEPS = 16;
	localparam int ATAN_ENTRIES = 30;
	localparam int FRAC = 30;
	localparam int QBITS = 35;              // quotient bits of a sine weight
	localparam int NLO = QBITS - FRAC;      // numerator bits fed in by the divider
	localparam int DW = 33;                 // divisor and numerator magnitude width
	localparam int RW = DW + 1;             // partial remainder width

	// stage numbers, counted from the input register
	localparam int S_PROD = 1;
	localparam int S_DOT = 2;
	localparam int S_SQ = 3;
	localparam int S_X2 = 4;
	localparam int S_ANG = 15;
	localparam int S_DPREP = S_ANG + SINE_STEPS + 1;
	localparam int S_WT = S_DPREP + QBITS + 1;
	localparam int S_MUL = S_WT + 1;
	localparam int S_OUT = S_MUL + 1;

	localparam logic [30:0] THR_RESET = 31'd10737;
	localparam logic [16:0] T_ONE = 17'd65536;

	localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
	localparam logic signed [35:0] HALFPI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] POLY_C1 = 36'sd958206130;
	localparam logic signed [35:0] POLY_C3 = 36'sd1818063951;
	localparam logic signed [35:0] POLY_C5 = -36'sd4137916448;
	localparam logic signed [35:0] POLY_C7 = 36'sd3048281098;
	localparam logic [QBITS-1:0] WLIM = 35'd17179869184;

	typedef struct packed {
		logic [3:0][15:0] a;
		logic [3:0][15:0] b;
		logic [16:0] t;
		logic [30:0] c;
		logic [30:0] x2;
		logic neg;
		logic cond;
	} side_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [35:0] z;
	} cl_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [QBITS-1:0] q;
	} dl_t;

	typedef struct packed {
		dl_t [1:0] ln;
		logic [DW-1:0] d;
		logic [1:0][NLO-1:0] nlo;
		logic [1:0] sgn;
		logic [1:0] ovf;
		logic dz;
	} dv_t;

	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		logic signed [35:0] r;
		unique case (i)
			5'd0: r = 36'sd843314856;
			5'd1: r = 36'sd497837829;
			5'd2: r = 36'sd263043836;
			5'd3: r = 36'sd133525158;
			5'd4: r = 36'sd67021686;
			5'd5: r = 36'sd33543515;
			5'd6: r = 36'sd16775850;
			5'd7: r = 36'sd8388437;
			5'd8: r = 36'sd4194282;
			5'd9: r = 36'sd2097149;
			5'd10: r = 36'sd1048575;
			5'd11: r = 36'sd524287;
			5'd12: r = 36'sd262143;
			5'd13: r = 36'sd131071;
			5'd14: r = 36'sd65535;
			5'd15: r = 36'sd32767;
			5'd16: r = 36'sd16383;
			5'd17: r = 36'sd8191;
			5'd18: r = 36'sd4095;
			5'd19: r = 36'sd2047;
			5'd20: r = 36'sd1023;
			5'd21: r = 36'sd511;
			5'd22: r = 36'sd255;
			5'd23: r = 36'sd127;
			5'd24: r = 36'sd63;
			5'd25: r = 36'sd31;
			5'd26: r = 36'sd15;
			5'd27: r = 36'sd7;
			5'd28: r = 36'sd3;
			5'd29: r = 36'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// round half up, then drop 30 fraction bits
	function automatic logic signed [35:0] rnd30(input logic signed [67:0] m);
		logic signed [67:0] s;
		s = (m + 68'sd536870912) >>> FRAC;
		return s[35:0];
	endfunction

	function automatic cl_t cordic_step(input cl_t v, input logic [4:0] i);
		cl_t r;
		logic signed [32:0] xs;
		logic signed [32:0] ys;
		xs = v.x >>> i;
		ys = v.y >>> i;
		if (!v.z[35]) begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - atan_q30(i);
		end else begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + atan_q30(i);
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] mag33(input logic signed [32:0] v);
		return v[32] ? DW'(-v) : DW'(v);
	endfunction

	// one restoring division step
	function automatic dl_t div_step(input dl_t v, input logic [DW-1:0] d, input logic nb);
		dl_t r;
		logic [RW-1:0] sh;
		sh = {v.rem[RW-2:0], nb};
		if (sh >= {1'b0, d}) begin
			r.rem = sh - {1'b0, d};
			r.q = {v.q[QBITS-2:0], 1'b1};
		end else begin
			r.rem = sh;
			r.q = {v.q[QBITS-2:0], 1'b0};
		end
		return r;
	endfunction

	// clamp quotient magnitude and apply sign
	function automatic logic signed [35:0] wsel(input logic [QBITS-1:0] q, input logic ovf,
			input logic sgn);
		logic [QBITS-1:0] m;
		m = (ovf || q > WLIM) ? WLIM : q;
		return sgn ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic [15:0] sat_round(input logic signed [51:0] p0,
			input logic signed [51:0] p1);
		logic signed [52:0] s;
		logic signed [52:0] v;
		logic [15:0] r;
		s = p0 + p1 + 53'sd536870912;
		v = s >>> FRAC;
		if (v > 53'sd32767) begin
			r = 16'h7fff;
		end else if (v < -53'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== src/quaternion_slerp.sv =====
`timescale 1ns / 1ps

// channel   | signals                                   | direction | handshake
// ----------+-------------------------------------------+-----------+--------------------------
// item in   | start, busy, q0_x..q0_w, q1_x..q1_w, blend | in        | start while busy low
// result    | done, d_x, d_y, d_z, d_w, used_linear     | out       | done high for one cycle
// config    | psel, penable, pwrite, paddr, pwdata,     | in/out    | apb write on access cycle
//           | prdata, pready                            |           |
//
// pipe: 14 stages for dot product, polynomial and angles, one to load the cordic, one per
// cordic step, one to set up the dividers, one per quotient bit of the restoring dividers,
// then weight, multiply and round stages
// one item is taken every cycle; busy stays low, since nothing ever holds the pipe
// arst_n clears the valid chain and resets thr_q; data registers keep junk
// results cannot be stalled: done marks each one for exactly one cycle

module quaternion_slerp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] q0_x,
	input  logic signed [15:0] q0_y,
	input  logic signed [15:0] q0_z,
	input  logic signed [15:0] q0_w,
	input  logic signed [15:0] q1_x,
	input  logic signed [15:0] q1_y,
	input  logic signed [15:0] q1_z,
	input  logic signed [15:0] q1_w,
	input  logic        [16:0] blend,
	output logic               done,
	output logic signed [15:0] d_x,
	output logic signed [15:0] d_y,
	output logic signed [15:0] d_z,
	output logic signed [15:0] d_w,
	output logic               used_linear,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [2:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);

	// configuration register
	logic [30:0] thr_q;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {1'b0, thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= qslerp_pkg::THR_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			thr_q <= pwdata[30:0];
		end
	end

	assign busy = 1'b0;

	// valid bit for each stage
	logic [qslerp_pkg::S_OUT:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[qslerp_pkg::S_OUT-1:1], start && !busy};
		end
	end

	assign done = vld_s[qslerp_pkg::S_OUT];

	// item fields that ride along the pipe
	qslerp_pkg::side_t side_s [1:qslerp_pkg::S_WT];

	logic signed [15:0] qa [4];
	logic signed [15:0] qb [4];

	assign qa[0] = q0_x;
	assign qa[1] = q0_y;
	assign qa[2] = q0_z;
	assign qa[3] = q0_w;
	assign qb[0] = q1_x;
	assign qb[1] = q1_y;
	assign qb[2] = q1_z;
	assign qb[3] = q1_w;

	// stage 1: component products, blend clamped to one
	logic signed [31:0] prod_s1 [4];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= qa[k] * qb[k];
			side_s[1].a[k] <= qa[k];
			side_s[1].b[k] <= qb[k];
		end
		side_s[1].t <= (blend > qslerp_pkg::T_ONE) ? qslerp_pkg::T_ONE : blend;
		side_s[1].c <= '0;
		side_s[1].x2 <= '0;
		side_s[1].neg <= 1'b0;
		side_s[1].cond <= 1'b0;
	end

	// stage 2: dot product, folded to the short arc
	logic signed [33:0] dot_c;
	logic        [33:0] cabs_c;
	logic        [33:0] cabs_s2;

	assign dot_c = prod_s1[0] + prod_s1[1] + prod_s1[2] + prod_s1[3];
	assign cabs_c = dot_c[33] ? 34'(-dot_c) : 34'(dot_c);

	always_ff @(posedge clk) begin
		cabs_s2 <= cabs_c;
	end

	// stage 3: threshold test and c squared
	logic        cond_c;
	logic [61:0] sq_s3;

	assign cond_c = (36'(qslerp_pkg::ONE_Q30) - $signed({2'b00, cabs_s2}))
		> $signed({5'b0, thr_q});

	always_ff @(posedge clk) begin
		sq_s3 <= cabs_s2[30:0] * cabs_s2[30:0];
	end

	// stage 4: x squared in q1.30
	logic [61:0] sqr_c;

	assign sqr_c = sq_s3 + 62'd536870912;

	// pass-along with the values each early stage adds
	for (genvar gi = 2; gi <= qslerp_pkg::S_WT; gi++) begin : g_side
		always_ff @(posedge clk) begin
			qslerp_pkg::side_t nx;
			nx = side_s[gi-1];
			if (gi == qslerp_pkg::S_DOT) begin
				nx.c = cabs_c[30:0];
				nx.neg = dot_c[33];
			end
			if (gi == qslerp_pkg::S_SQ) begin
				nx.cond = cond_c;
			end
			if (gi == qslerp_pkg::S_X2) begin
				nx.x2 = sqr_c[60:30];
			end
			side_s[gi] <= nx;
		end
	end

	// stages 5 to 12: horner polynomial for the angle, multiply and round alternate
	logic signed [67:0] m7_s5;
	logic signed [35:0] p5_s6;
	logic signed [67:0] m5_s7;
	logic signed [35:0] p3_s8;
	logic signed [67:0] m3_s9;
	logic signed [35:0] p1_s10;
	logic signed [67:0] m1_s11;
	logic signed [35:0] om_s12;

	always_ff @(posedge clk) begin
		m7_s5 <= $signed({1'b0, side_s[4].x2}) * qslerp_pkg::POLY_C7;
		p5_s6 <= qslerp_pkg::POLY_C5 + qslerp_pkg::rnd30(m7_s5);
		m5_s7 <= $signed({1'b0, side_s[6].x2}) * p5_s6;
		p3_s8 <= qslerp_pkg::POLY_C3 + qslerp_pkg::rnd30(m5_s7);
		m3_s9 <= $signed({1'b0, side_s[8].x2}) * p3_s8;
		p1_s10 <= qslerp_pkg::POLY_C1 + qslerp_pkg::rnd30(m3_s9);
		m1_s11 <= $signed({1'b0, side_s[10].c}) * p1_s10;
		om_s12 <= qslerp_pkg::HALFPI_Q30 - qslerp_pkg::rnd30(m1_s11);
	end

	// stages 13 and 14: t times omega
	logic signed [53:0] twm_s13;
	logic signed [35:0] om_s13;
	logic signed [35:0] om_s14;
	logic signed [35:0] tw_s14;
	logic signed [53:0] twr_c;

	assign twr_c = (twm_s13 + 54'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		twm_s13 <= $signed({1'b0, side_s[12].t}) * om_s12;
		om_s13 <= om_s12;
		tw_s14 <= twr_c[35:0];
		om_s14 <= om_s13;
	end

	// cordic: three rotations side by side, lane 0 sin(omega), lane 1 the q0 weight,
	// lane 2 the q1 weight; each stage does one micro-rotation
	qslerp_pkg::cl_t [2:0] cor_s [0:qslerp_pkg::SINE_STEPS];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			cor_s[0][l].x <= 33'sd1073741824;
			cor_s[0][l].y <= '0;
		end
		cor_s[0][0].z <= om_s14;
		cor_s[0][1].z <= om_s14 - tw_s14;
		cor_s[0][2].z <= tw_s14;
	end

	for (genvar gc = 0; gc < qslerp_pkg::SINE_STEPS; gc++) begin : g_cordic
		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				cor_s[gc+1][l] <= qslerp_pkg::cordic_step(cor_s[gc][l], 5'(gc));
			end
		end
	end

	// divider set-up: magnitudes, signs, early overflow for quotients past 2^35
	qslerp_pkg::dv_t dv_s [0:qslerp_pkg::QBITS];

	logic [qslerp_pkg::DW-1:0] dd_c;
	logic [qslerp_pkg::DW-1:0] nn_c [2];

	assign dd_c = qslerp_pkg::mag33(cor_s[qslerp_pkg::SINE_STEPS][0].y);
	assign nn_c[0] = qslerp_pkg::mag33(cor_s[qslerp_pkg::SINE_STEPS][1].y);
	assign nn_c[1] = qslerp_pkg::mag33(cor_s[qslerp_pkg::SINE_STEPS][2].y);

	always_ff @(posedge clk) begin
		dv_s[0].d <= dd_c;
		dv_s[0].dz <= (cor_s[qslerp_pkg::SINE_STEPS][0].y == '0);
		for (int l = 0; l < 2; l++) begin
			dv_s[0].ln[l].rem <= {1'b0, nn_c[l] >> qslerp_pkg::NLO};
			dv_s[0].ln[l].q <= '0;
			dv_s[0].nlo[l] <= nn_c[l][qslerp_pkg::NLO-1:0];
			dv_s[0].ovf[l] <= (nn_c[l] >> qslerp_pkg::NLO) >= dd_c;
			dv_s[0].sgn[l] <= cor_s[qslerp_pkg::SINE_STEPS][l+1].y[32]
				^ cor_s[qslerp_pkg::SINE_STEPS][0].y[32];
		end
	end

	// restoring division, one quotient bit per stage; numerator is n * 2^30
	for (genvar gj = 0; gj < qslerp_pkg::QBITS; gj++) begin : g_div
		localparam int B = qslerp_pkg::QBITS - 1 - gj;
		logic [1:0] nb;
		if (B >= qslerp_pkg::FRAC) begin : g_hi
			assign nb[0] = dv_s[gj].nlo[0][B-qslerp_pkg::FRAC];
			assign nb[1] = dv_s[gj].nlo[1][B-qslerp_pkg::FRAC];
		end else begin : g_lo
			assign nb = 2'b00;
		end
		always_ff @(posedge clk) begin
			qslerp_pkg::dv_t nx;
			nx = dv_s[gj];
			for (int l = 0; l < 2; l++) begin
				nx.ln[l] = qslerp_pkg::div_step(dv_s[gj].ln[l], dv_s[gj].d, nb[l]);
			end
			dv_s[gj+1] <= nx;
		end
	end

	// weight stage: sine weights, or 1 - t and t when close or sine vanished
	logic signed [35:0] w0_sw;
	logic signed [35:0] w1_sw;
	logic               lin_sw;
	logic               lin_c;
	logic signed [35:0] lw0_c;
	logic signed [35:0] lw1_c;
	logic signed [35:0] w1_c;

	assign lin_c = !side_s[qslerp_pkg::S_WT-1].cond || dv_s[qslerp_pkg::QBITS].dz;
	assign lw0_c = $signed({5'b0, qslerp_pkg::T_ONE - side_s[qslerp_pkg::S_WT-1].t, 14'b0});
	assign lw1_c = $signed({5'b0, side_s[qslerp_pkg::S_WT-1].t, 14'b0});
	assign w1_c = lin_c ? lw1_c : qslerp_pkg::wsel(dv_s[qslerp_pkg::QBITS].ln[1].q,
		dv_s[qslerp_pkg::QBITS].ovf[1], dv_s[qslerp_pkg::QBITS].sgn[1]);

	always_ff @(posedge clk) begin
		w0_sw <= lin_c ? lw0_c : qslerp_pkg::wsel(dv_s[qslerp_pkg::QBITS].ln[0].q,
			dv_s[qslerp_pkg::QBITS].ovf[0], dv_s[qslerp_pkg::QBITS].sgn[0]);
		w1_sw <= side_s[qslerp_pkg::S_WT-1].neg ? -w1_c : w1_c;
		lin_sw <= lin_c;
	end

	// multiply stage
	logic signed [51:0] pr0_sm [4];
	logic signed [51:0] pr1_sm [4];
	logic               lin_sm;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			pr0_sm[k] <= w0_sw * $signed(side_s[qslerp_pkg::S_WT].a[k]);
			pr1_sm[k] <= w1_sw * $signed(side_s[qslerp_pkg::S_WT].b[k]);
		end
		lin_sm <= lin_sw;
	end

	// output stage: sum, round, saturate
	always_ff @(posedge clk) begin
		d_x <= qslerp_pkg::sat_round(pr0_sm[0], pr1_sm[0]);
		d_y <= qslerp_pkg::sat_round(pr0_sm[1], pr1_sm[1]);
		d_z <= qslerp_pkg::sat_round(pr0_sm[2], pr1_sm[2]);
		d_w <= qslerp_pkg::sat_round(pr0_sm[3], pr1_sm[3]);
		used_linear <= lin_sm;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(qslerp_pkg::S_OUT) done)
		else $error("item did not come out after the pipeline latency");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, qslerp_pkg::S_OUT))
		else $error("result without a matching item");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	// one input item: components in x, y, z, w order
	typedef struct packed {
		logic [3:0][15:0] a;
		logic [3:0][15:0] b;
		logic [16:0] t;
	} pair_t;

	// one blended result
	typedef struct packed {
		logic [3:0][15:0] d;
		logic lin;
	} blend_t;

	localparam longint Q30 = 64'sd1073741824;
	localparam longint HALFPI = 64'sd1686629713;
	localparam longint K1 = 64'sd958206130;
	localparam longint K3 = 64'sd1818063951;
	localparam longint K5 = -64'sd4137916448;
	localparam longint K7 = 64'sd3048281098;
	localparam longint WCLAMP = 64'sd17179869184;
	localparam int SETTLE = qslerp_pkg::S_OUT + 8;
	localparam int STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] q0_x = '0, q0_y = '0, q0_z = '0, q0_w = '0;
	logic signed [15:0] q1_x = '0, q1_y = '0, q1_z = '0, q1_w = '0;
	logic [16:0] blend = '0;
	logic done;
	logic signed [15:0] d_x, d_y, d_z, d_w;
	logic used_linear;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// arctangent table in Q2.30, one entry per rotation
	longint arctan [30] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048575, 524287, 262143, 131071, 65535,
		32767, 16383, 8191, 4095, 2047,
		1023, 511, 255, 127, 63,
		31, 15, 7, 3, 1};

	pair_t pending_pairs [$];
	blend_t awaited_blends [$];
	pair_t on_port;
	longint thr_shadow = 10737;
	int errors = 0;
	int gap = 0;
	int stall_cycles = 0;
	bit quiet = 0;

	always #6 clk = ~clk;

	quaternion_slerp i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.q0_x(q0_x), .q0_y(q0_y), .q0_z(q0_z), .q0_w(q0_w),
		.q1_x(q1_x), .q1_y(q1_y), .q1_z(q1_z), .q1_w(q1_w),
		.blend(blend), .done(done),
		.d_x(d_x), .d_y(d_y), .d_z(d_z), .d_w(d_w), .used_linear(used_linear),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// half-up rounding shift on a signed value
	function automatic longint rshift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// cordic from (1, 0); the gain stays in the result
	function automatic longint cordic_sin(longint ang);
		longint x, y, z, xs, ys;
		x = Q30;
		y = 0;
		z = ang;
		for (int i = 0; i < qslerp_pkg::SINE_STEPS && i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arctan[i];
			end else begin
				x += ys; y -= xs; z += arctan[i];
			end
		end
		return y;
	endfunction

	function automatic longint ratio_weight(longint s, longint den);
		longint w;
		w = (s * Q30) / den;
		if (w > WCLAMP) w = WCLAMP;
		if (w < -WCLAMP) w = -WCLAMP;
		return w;
	endfunction

	function automatic blend_t slerp_predict(pair_t p);
		blend_t r;
		longint a [4], b [4];
		longint t, c, w0, w1, x2, poly, omega, tw, sinom, v;
		bit flip;
		c = 0;
		flip = 0;
		r.lin = 1'b1;
		for (int k = 0; k < 4; k++) begin
			a[k] = longint'($signed(p.a[k]));
			b[k] = longint'($signed(p.b[k]));
			c += a[k] * b[k];
		end
		t = (p.t > qslerp_pkg::T_ONE) ? 65536 : longint'(p.t);
		if (c < 0) begin
			c = -c;
			flip = 1;
		end
		w0 = (65536 - t) * 16384;
		w1 = t * 16384;
		if (Q30 - c > thr_shadow) begin
			x2 = rshift(c * c, 30);
			poly = K5 + rshift(x2 * K7, 30);
			poly = K3 + rshift(x2 * poly, 30);
			poly = K1 + rshift(x2 * poly, 30);
			omega = HALFPI - rshift(c * poly, 30);
			tw = rshift(t * omega, 16);
			sinom = cordic_sin(omega);
			if (sinom != 0) begin
				w0 = ratio_weight(cordic_sin(omega - tw), sinom);
				w1 = ratio_weight(cordic_sin(tw), sinom);
				r.lin = 1'b0;
			end
		end
		if (flip) w1 = -w1;
		for (int k = 0; k < 4; k++) begin
			v = rshift(w0 * a[k] + w1 * b[k], 30);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			r.d[k] = v[15:0];
		end
		return r;
	endfunction

	// random unit quaternion in Q1.15
	function automatic logic [3:0][15:0] unit_quat();
		real q [4];
		real n;
		logic [3:0][15:0] r;
		n = 0.0;
		for (int k = 0; k < 4; k++) begin
			q[k] = (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
			n += q[k] * q[k];
		end
		if (n < 1.0e-6) begin
			q[3] = 1.0;
			n = 1.0;
		end
		n = $sqrt(n);
		for (int k = 0; k < 4; k++) r[k] = 16'($rtoi(q[k] / n * 32767.0));
		return r;
	endfunction

	// small random turn away from q, renormalised
	function automatic logic [3:0][15:0] nudge(logic [3:0][15:0] q, int spread);
		real v [4];
		real n;
		logic [3:0][15:0] r;
		n = 0.0;
		for (int k = 0; k < 4; k++) begin
			v[k] = real'($signed(q[k])) + real'($urandom_range(0, 2 * spread)) - spread;
			n += v[k] * v[k];
		end
		n = $sqrt(n);
		if (n < 1.0) n = 1.0;
		for (int k = 0; k < 4; k++) r[k] = 16'($rtoi(v[k] / n * 32767.0));
		return r;
	endfunction

	function automatic logic [16:0] rand_blend();
		if ($urandom_range(0, 19) == 0) return 17'($urandom_range(65536, 131071));
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 17'd0 : qslerp_pkg::T_ONE;
		return 17'($urandom_range(0, 65536));
	endfunction

	task automatic queue_pair(logic [3:0][15:0] a, logic [3:0][15:0] b, logic [16:0] t);
		pair_t p;
		p.a = a;
		p.b = b;
		p.t = t;
		pending_pairs.push_back(p);
	endtask

	// mostly unit pairs, some close together, some flipped, some raw noise
	task automatic queue_random(int n);
		logic [3:0][15:0] a, b;
		int kind;
		repeat (n) begin
			kind = $urandom_range(0, 9);
			a = unit_quat();
			if (kind < 3) b = unit_quat();
			else if (kind < 6) b = nudge(a, $urandom_range(1, 3000));
			else if (kind < 8) begin
				b = nudge(a, $urandom_range(1, 400));
				for (int k = 0; k < 4; k++) b[k] = -$signed(b[k]);
			end else begin
				a = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
				b = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
			end
			queue_pair(a, b, rand_blend());
		end
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// pipe empty, then room for anything still in flight
	task automatic drain();
		while (pending_pairs.size() != 0 || awaited_blends.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_threshold(logic [30:0] v);
		apb_write(3'd0, {1'b0, v});
		thr_shadow = longint'(v);
	endtask

	// item driver: accepts, predicts, then lines up the next item or a gap
	always @(posedge clk) begin
		logic nxt;
		if (start && !busy && arst_n) begin
			awaited_blends.push_back(slerp_predict(on_port));
			void'(pending_pairs.pop_front());
		end
		nxt = 1'b0;
		if (gap > 0) begin
			gap--;
		end else if (pending_pairs.size() != 0) begin
			if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 13) - 1;
			end else begin
				nxt = 1'b1;
				on_port = pending_pairs[0];
				q0_x <= on_port.a[0]; q0_y <= on_port.a[1];
				q0_z <= on_port.a[2]; q0_w <= on_port.a[3];
				q1_x <= on_port.b[0]; q1_y <= on_port.b[1];
				q1_z <= on_port.b[2]; q1_w <= on_port.b[3];
				blend <= on_port.t;
			end
		end
		start <= nxt;
	end

	// result checker
	always @(posedge clk) begin
		blend_t want;
		if (arst_n && done) begin
			if (awaited_blends.size() == 0) begin
				$display("%0t: unexpected result d=%h %h %h %h lin=%b", $time,
					d_x, d_y, d_z, d_w, used_linear);
				errors++;
			end else begin
				want = awaited_blends.pop_front();
				if (d_x !== want.d[0]) begin
					$display("%0t: d_x expected %h got %h", $time, want.d[0], d_x);
					errors++;
				end
				if (d_y !== want.d[1]) begin
					$display("%0t: d_y expected %h got %h", $time, want.d[1], d_y);
					errors++;
				end
				if (d_z !== want.d[2]) begin
					$display("%0t: d_z expected %h got %h", $time, want.d[2], d_z);
					errors++;
				end
				if (d_w !== want.d[3]) begin
					$display("%0t: d_w expected %h got %h", $time, want.d[3], d_w);
					errors++;
				end
				if (used_linear !== want.lin) begin
					$display("%0t: used_linear expected %b got %b", $time, want.lin,
						used_linear);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((start && !busy) || (arst_n && done) || (psel && penable))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		logic [3:0][15:0] u, v;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset threshold
		u = unit_quat();
		v = unit_quat();
		queue_pair(u, v, 17'd0);
		queue_pair(u, v, qslerp_pkg::T_ONE);
		queue_pair(u, v, 17'd32768);
		queue_pair(u, v, 17'h1ffff);                   // blend above one
		queue_pair(u, u, 17'd20000);                   // identical pair
		queue_pair(u, nudge(u, 50), 17'd40000);        // close pair, linear weights
		v = nudge(u, 50);
		for (int k = 0; k < 4; k++) v[k] = -$signed(v[k]);
		queue_pair(u, v, 17'd12345);                   // negative dot product
		queue_pair({16'h7fff, 16'd0, 16'd0, 16'd0}, {16'd0, 16'h7fff, 16'd0, 16'd0},
			17'd30000);                                // zero dot product
		queue_pair({4{16'h7fff}}, {4{16'h7fff}}, 17'd5000);  // dot product above one
		queue_pair({4{16'h8000}}, {4{16'h8000}}, 17'd5000);
		queue_pair({4{16'h8000}}, {4{16'h7fff}}, 17'd60000);
		queue_pair({16'h7fff, 16'd0, 16'd0, 16'd0}, {16'h7ffe, 16'd181, 16'd0, 16'd0},
			17'd32768);                                // tiny angle
		queue_random(8);
		drain();

		// zero threshold: sine weights even for nearly equal pairs
		set_threshold(31'd0);
		queue_pair(u, u, 17'd32768);
		queue_pair({16'h7fff, 16'd0, 16'd0, 16'd0}, {16'h7fff, 16'd0, 16'd0, 16'd0},
			17'd1000);                                 // vanishing sine
		queue_pair(u, nudge(u, 2), 17'd50000);
		queue_random(100);
		drain();

		// threshold of one: linear weights throughout
		set_threshold(31'd1073741824);
		queue_random(80);
		drain();

		set_threshold(31'($urandom_range(0, 1073741824)));
		queue_random(80);
		drain();

		set_threshold(31'($urandom_range(0, 4000000)));
		queue_random(100);
		drain();

		// back to the default, last stretch runs back to back
		set_threshold(qslerp_pkg::THR_RESET);
		quiet = 1;
		queue_random(120);
		drain();

		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== quaternion_slerp.f =====
src/qslerp_pkg.sv
src/quaternion_slerp.sv
bench/testbench.sv
